@@ sv/xcfr_pkg.sv @@
// ----------------------------------------------------------------------------
// xcfr_pkg
// shared widths, codes and controller/datapath signal groups of the
// xor-checked frame receiver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xcfr_pkg;

    localparam int BYTE_W         = 8;
    localparam int STATUS_W       = 2;
    localparam int PARAM_CNT_W    = 5;
    localparam int PARAM_IDX_W    = 4;
    localparam int MAX_PARAMS     = 16;
    localparam int FRAME_OVERHEAD = 1 + 1 + 1 + 1;
    localparam int CFG_IDX_W      = 8;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_CRC = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LEN = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 8'd1;

    // controller to datapath
    typedef struct packed {
        logic                cap_len;
        logic                cap_cmd;
        logic                cap_param;
        logic                cap_check;
        logic                cap_ack;
        logic                out_load;
        logic [STATUS_W-1:0] out_kind;
        logic                emit_adv;
    } xcfr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start_hit;
        logic end_hit;
        logic len_bad;
        logic xor_ok;
        logic params_zero;
        logic params_done;
        logic emit_last;
        logic out_free;
    } xcfr_sts_t;

endpackage

@@ sv/xcfr_ifs.sv @@
// ----------------------------------------------------------------------------
// xcfr_ifs
// valid/ready channels of the frame receiver: received bytes, result
// items and register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface xcfr_byte_if
    import xcfr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface xcfr_item_if
    import xcfr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [STATUS_W-1:0]    status;
    logic [BYTE_W-1:0]      command_code;
    logic [BYTE_W-1:0]      ack_value;
    logic [PARAM_CNT_W-1:0] param_total;
    logic [PARAM_IDX_W-1:0] param_index;
    logic [BYTE_W-1:0]      param_value;
    logic                   last;

    modport source (output valid, output status, output command_code,
                    output ack_value, output param_total, output param_index,
                    output param_value, output last, input ready);
    modport sink   (input valid, input status, input command_code,
                    input ack_value, input param_total, input param_index,
                    input param_value, input last, output ready);
endinterface

interface xcfr_cfg_if
    import xcfr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/xcfr_datapath.sv @@
// ----------------------------------------------------------------------------
// xcfr_datapath
// marker registers, frame fields, parameter store, running xor and the
// result output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcfr_datapath
    import xcfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [BYTE_W-1:0]      rx_byte,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data,
    input  xcfr_cmd_t              cmd,
    output xcfr_sts_t              sts,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [STATUS_W-1:0]    out_status,
    output logic [BYTE_W-1:0]      out_command,
    output logic [BYTE_W-1:0]      out_ack,
    output logic [PARAM_CNT_W-1:0] out_total,
    output logic [PARAM_IDX_W-1:0] out_index,
    output logic [BYTE_W-1:0]      out_value,
    output logic                   out_last
);

    logic [BYTE_W-1:0]      start_marker_reg;
    logic [BYTE_W-1:0]      end_marker_reg;
    logic [BYTE_W-1:0]      held_command_reg;
    logic [BYTE_W-1:0]      running_xor_reg;
    logic [BYTE_W-1:0]      received_check_reg;
    logic [BYTE_W-1:0]      held_ack_reg;
    logic [PARAM_CNT_W-1:0] expected_reg;
    logic [PARAM_CNT_W-1:0] seen_reg;
    logic [PARAM_IDX_W-1:0] emit_idx_reg;
    logic [PARAM_IDX_W-1:0] emit_idx_next;
    logic [BYTE_W-1:0]      rd_data_reg;
    logic [BYTE_W-1:0]      param_mem [MAX_PARAMS];

    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    out_status_reg;
    logic [BYTE_W-1:0]      out_command_reg;
    logic [BYTE_W-1:0]      out_ack_reg;
    logic [PARAM_CNT_W-1:0] out_total_reg;
    logic [PARAM_IDX_W-1:0] out_index_reg;
    logic [BYTE_W-1:0]      out_value_reg;
    logic                   out_last_reg;

    // status toward the controller
    always_comb
    begin
        sts.start_hit   = (rx_byte == start_marker_reg);
        sts.end_hit     = (rx_byte == end_marker_reg);
        sts.len_bad     = (rx_byte < BYTE_W'(FRAME_OVERHEAD))
                       || (rx_byte > BYTE_W'(MAX_PARAMS + FRAME_OVERHEAD));
        sts.xor_ok      = (running_xor_reg == received_check_reg);
        sts.params_zero = (expected_reg == '0);
        sts.params_done = ({1'b0, seen_reg} + (PARAM_CNT_W+1)'(1))
                       >= {1'b0, expected_reg};
        sts.emit_last   = ({1'b0, emit_idx_reg} + PARAM_CNT_W'(1)) == expected_reg;
        sts.out_free    = !out_valid_reg || out_ready;
    end

    // marker registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= 8'd2;
            end_marker_reg   <= 8'd3;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_START_MARKER)
                start_marker_reg <= cfg_data;
            if (cfg_index == REG_END_MARKER)
                end_marker_reg <= cfg_data;
        end
    end

    // frame fields
    always_ff @(posedge clk)
    begin
        if (cmd.cap_len)
            expected_reg <= PARAM_CNT_W'(rx_byte - BYTE_W'(FRAME_OVERHEAD));
        if (cmd.cap_cmd)
        begin
            held_command_reg <= rx_byte;
            running_xor_reg  <= rx_byte;
            seen_reg         <= '0;
        end
        if (cmd.cap_param)
        begin
            running_xor_reg <= running_xor_reg ^ rx_byte;
            seen_reg        <= seen_reg + PARAM_CNT_W'(1);
        end
        if (cmd.cap_check)
            received_check_reg <= rx_byte;
        if (cmd.cap_ack)
            held_ack_reg <= rx_byte;
    end

    // parameter store; read data is registered from the next emit index, so it matches the current emit index
    always_ff @(posedge clk)
    begin
        if (cmd.cap_param)
            param_mem[seen_reg[PARAM_IDX_W-1:0]] <= rx_byte;
        rd_data_reg <= param_mem[emit_idx_next];
    end

    always_comb
    begin
        emit_idx_next = emit_idx_reg;
        if (cmd.emit_adv)
            emit_idx_next = sts.emit_last ? '0 : emit_idx_reg + PARAM_IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            emit_idx_reg <= '0;
        else
            emit_idx_reg <= emit_idx_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_kind;
            unique case (cmd.out_kind)
                STATUS_LEN:
                begin
                    out_command_reg <= '0;
                    out_ack_reg     <= '0;
                    out_total_reg   <= '0;
                    out_index_reg   <= '0;
                    out_value_reg   <= '0;
                    out_last_reg    <= 1'b1;
                end
                STATUS_CRC:
                begin
                    out_command_reg <= held_command_reg;
                    out_ack_reg     <= held_ack_reg;
                    out_total_reg   <= expected_reg;
                    out_index_reg   <= '0;
                    out_value_reg   <= '0;
                    out_last_reg    <= 1'b1;
                end
                default:
                begin
                    out_command_reg <= held_command_reg;
                    out_ack_reg     <= held_ack_reg;
                    out_total_reg   <= expected_reg;
                    if (sts.params_zero)
                    begin
                        out_index_reg <= '0;
                        out_value_reg <= '0;
                        out_last_reg  <= 1'b1;
                    end
                    else
                    begin
                        out_index_reg <= emit_idx_reg;
                        out_value_reg <= rd_data_reg;
                        out_last_reg  <= sts.emit_last;
                    end
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_command = out_command_reg;
    assign out_ack     = out_ack_reg;
    assign out_total   = out_total_reg;
    assign out_index   = out_index_reg;
    assign out_value   = out_value_reg;
    assign out_last    = out_last_reg;

endmodule

@@ sv/xcfr_controller.sv @@
// ----------------------------------------------------------------------------
// xcfr_controller
// frame phase state machine; steers captures and result loads
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcfr_controller
    import xcfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  xcfr_sts_t sts,
    output xcfr_cmd_t cmd
);

    localparam logic [2:0] ST_WAIT   = 3'd0;
    localparam logic [2:0] ST_LEN    = 3'd1;
    localparam logic [2:0] ST_CMD    = 3'd2;
    localparam logic [2:0] ST_PARAMS = 3'd3;
    localparam logic [2:0] ST_CHECK  = 3'd4;
    localparam logic [2:0] ST_ACK    = 3'd5;
    localparam logic [2:0] ST_END    = 3'd6;
    localparam logic [2:0] ST_EMIT   = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       in_fire;

    // only length and end bytes can produce an item right away
    assign in_ready = (state_reg != ST_EMIT)
                   && (sts.out_free || !((state_reg == ST_LEN) || (state_reg == ST_END)));
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.out_kind = STATUS_OK;
        unique case (state_reg)
            ST_WAIT:
                if (in_fire)
                    state_next = sts.start_hit ? ST_LEN : ST_WAIT;
            ST_LEN:
                if (in_fire)
                begin
                    cmd.cap_len = 1'b1;
                    if (sts.len_bad)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = STATUS_LEN;
                        state_next   = ST_WAIT;
                    end
                    else
                        state_next = ST_CMD;
                end
            ST_CMD:
                if (in_fire)
                begin
                    cmd.cap_cmd = 1'b1;
                    state_next  = sts.params_zero ? ST_CHECK : ST_PARAMS;
                end
            ST_PARAMS:
                if (in_fire)
                begin
                    cmd.cap_param = 1'b1;
                    if (sts.params_done)
                        state_next = ST_CHECK;
                end
            ST_CHECK:
                if (in_fire)
                begin
                    cmd.cap_check = 1'b1;
                    state_next    = ST_ACK;
                end
            ST_ACK:
                if (in_fire)
                begin
                    cmd.cap_ack = 1'b1;
                    state_next  = ST_END;
                end
            ST_END:
                if (in_fire)
                begin
                    state_next = ST_WAIT;
                    if (sts.end_hit)
                    begin
                        if (!sts.xor_ok)
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_kind = STATUS_CRC;
                        end
                        else if (sts.params_zero)
                            cmd.out_load = 1'b1;
                        else
                            state_next = ST_EMIT;
                    end
                end
            default:
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.emit_adv = 1'b1;
                    if (sts.emit_last)
                        state_next = ST_WAIT;
                end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_WAIT;
        else
            state_reg <= state_next;
    end

endmodule

@@ sv/xor_checked_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver
// parses received bytes into marker-framed packets with an xor check byte
//
// rx takes one received byte per request; items gives result requests;
// cfg writes start_marker (index 0) and end_marker (index 1), always ready,
// other indexes ignored. write cfg only while the block is idle.
// a frame is start, length, command, length-4 params, check, ack, end.
// bytes are taken one per cycle while a frame is read in, unless items stalls.
// results: a length error, checksum error or parameterless frame item is
// registered, valid in the cycle after the byte that causes it; a parameter
// run passes the emit state and output register, then gives one item per
// cycle while items are taken, with rx held off until the last item loads.
// if items stalls, the output register holds its item and rx keeps taking
// bytes, except a length or end byte, which waits until the register frees.
// reset: markers return to 2 and 3, the parser waits for a start marker,
// no item is pending. param store contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xor_checked_frame_receiver
    import xcfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    xcfr_byte_if.sink   rx,
    xcfr_item_if.source items,
    xcfr_cfg_if.sink    cfg
);

    // command and status between sequencer and datapath
    xcfr_cmd_t cmd;
    xcfr_sts_t sts;

    // register writes are taken at once
    assign cfg.ready = 1'b1;

    xcfr_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // frame fields, param store and the result register
    xcfr_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx.rx_byte),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .cmd         (cmd),
        .sts         (sts),
        .out_ready   (items.ready),
        .out_valid   (items.valid),
        .out_status  (items.status),
        .out_command (items.command_code),
        .out_ack     (items.ack_value),
        .out_total   (items.param_total),
        .out_index   (items.param_index),
        .out_value   (items.param_value),
        .out_last    (items.last)
    );

endmodule

@@ test/xcfr_frame_checker.sv @@
// ----------------------------------------------------------------------------
// xcfr_frame_checker
// watches the byte, item and register channels of the frame receiver,
// parses the accepted bytes on its own and checks every result item
// against the oldest predicted one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcfr_frame_checker
    import xcfr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    xcfr_byte_if rx,
    xcfr_item_if items,
    xcfr_cfg_if  cfg,
    output int   error_count,
    output int   pending_count
);

    localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd2;
    localparam logic [BYTE_W-1:0] END_MARKER_RESET   = 8'd3;
    localparam int                REPORT_LIMIT       = 10;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LENGTH,
        PH_COMMAND,
        PH_PARAMS,
        PH_CHECK,
        PH_ACK,
        PH_END
    } parse_phase_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic [BYTE_W-1:0]      command_code;
        logic [BYTE_W-1:0]      ack_value;
        logic [PARAM_CNT_W-1:0] param_total;
        logic [PARAM_IDX_W-1:0] param_index;
        logic [BYTE_W-1:0]      param_value;
        logic                   last;
    } frame_item_t;

    frame_item_t            expected_items[$];
    frame_item_t            got_item;
    frame_item_t            want_item;

    logic [BYTE_W-1:0]      start_marker;
    logic [BYTE_W-1:0]      end_marker;
    parse_phase_t           phase;
    logic [BYTE_W-1:0]      command_byte;
    logic [BYTE_W-1:0]      frame_ack;
    logic [BYTE_W-1:0]      check_byte;
    logic [BYTE_W-1:0]      xor_sum;
    logic [PARAM_CNT_W-1:0] param_count;
    logic [PARAM_CNT_W-1:0] params_taken;
    logic [BYTE_W-1:0]      param_bytes [MAX_PARAMS];

    function automatic void queue_item(input logic [STATUS_W-1:0] status,
                                       input logic [PARAM_IDX_W-1:0] index,
                                       input logic [BYTE_W-1:0] value,
                                       input logic is_last);
        frame_item_t item;
        item.status       = status;
        item.command_code = (status == STATUS_LEN) ? '0 : command_byte;
        item.ack_value    = (status == STATUS_LEN) ? '0 : frame_ack;
        item.param_total  = (status == STATUS_LEN) ? '0 : param_count;
        item.param_index  = index;
        item.param_value  = value;
        item.last         = is_last;
        expected_items.push_back(item);
    endfunction

    // one received byte through the parser, queueing whatever it causes
    function automatic void absorb_byte(input logic [BYTE_W-1:0] b);
        case (phase)
            PH_LENGTH:
            begin
                if (b < FRAME_OVERHEAD || b > MAX_PARAMS + FRAME_OVERHEAD)
                begin
                    queue_item(STATUS_LEN, '0, '0, 1'b1);
                    phase = PH_HUNT;
                end
                else
                begin
                    param_count = PARAM_CNT_W'(b - FRAME_OVERHEAD);
                    phase       = PH_COMMAND;
                end
            end
            PH_COMMAND:
            begin
                command_byte = b;
                xor_sum      = b;
                params_taken = '0;
                phase        = (param_count != 0) ? PH_PARAMS : PH_CHECK;
            end
            PH_PARAMS:
            begin
                param_bytes[params_taken[PARAM_IDX_W-1:0]] = b;
                xor_sum      = xor_sum ^ b;
                params_taken = params_taken + 1'b1;
                if (params_taken >= param_count)
                    phase = PH_CHECK;
            end
            PH_CHECK:
            begin
                check_byte = b;
                phase      = PH_ACK;
            end
            PH_ACK:
            begin
                frame_ack = b;
                phase     = PH_END;
            end
            PH_END:
            begin
                // a wrong closing byte drops the frame and is never a new start
                if (b == end_marker)
                begin
                    if (xor_sum != check_byte)
                        queue_item(STATUS_CRC, '0, '0, 1'b1);
                    else if (param_count == 0)
                        queue_item(STATUS_OK, '0, '0, 1'b1);
                    else
                        for (int i = 0; i < param_count; i++)
                            queue_item(STATUS_OK, PARAM_IDX_W'(i), param_bytes[i],
                                       i + 1 == param_count);
                end
                phase = PH_HUNT;
            end
            default:
            begin
                if (b == start_marker)
                    phase = PH_LENGTH;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_items.delete();
            start_marker  = START_MARKER_RESET;
            end_marker    = END_MARKER_RESET;
            phase         = PH_HUNT;
            command_byte  = '0;
            frame_ack     = '0;
            check_byte    = '0;
            xor_sum       = '0;
            param_count   = '0;
            params_taken  = '0;
            error_count   <= 0;
            pending_count <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_START_MARKER: start_marker = cfg.data;
                    REG_END_MARKER:   end_marker   = cfg.data;
                    default:          ;
                endcase
            end

            if (items.valid && items.ready)
            begin
                got_item = '{items.status, items.command_code, items.ack_value,
                             items.param_total, items.param_index,
                             items.param_value, items.last};
                if (expected_items.size() == 0)
                begin
                    if (error_count < REPORT_LIMIT)
                        $display("%0t item check failed: unexpected item st=%0d cmd=%0h",
                                 $time, got_item.status, got_item.command_code);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want_item = expected_items.pop_front();
                    if (got_item !== want_item)
                    begin
                        if (error_count < REPORT_LIMIT)
                        begin
                            $display("%0t item check failed", $time);
                            $display("  want st=%0d cmd=%0h ack=%0h tot=%0d idx=%0d val=%0h last=%0b",
                                     want_item.status, want_item.command_code,
                                     want_item.ack_value, want_item.param_total,
                                     want_item.param_index, want_item.param_value,
                                     want_item.last);
                            $display("  got  st=%0d cmd=%0h ack=%0h tot=%0d idx=%0d val=%0h last=%0b",
                                     got_item.status, got_item.command_code,
                                     got_item.ack_value, got_item.param_total,
                                     got_item.param_index, got_item.param_value,
                                     got_item.last);
                        end
                        error_count <= error_count + 1;
                    end
                end
            end

            if (rx.valid && rx.ready)
                absorb_byte(rx.rx_byte);

            pending_count <= expected_items.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the xor-checked frame receiver: directed frames
// for every status and corner, a long output stall, then random frames
// under several marker settings and idle patterns; the checker beside the
// block predicts and compares every result item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import xcfr_pkg::*;

    localparam int SETTLE_CYCLES = 24;   // covers starting a parameter run, all its items and a margin
    localparam int HOLD_CYCLES   = 300;  // long output stall in the pressure test
    localparam int ROUND_BYTES   = 6;    // frame bytes a random round sends at least
    localparam int ROUNDS        = 5;

    // no such register: the write must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd9;

    typedef enum int {
        FILL_RANDOM,
        FILL_ZERO,
        FILL_ONES,
        FILL_RAMP
    } param_fill_t;

    logic clk = 1'b0;
    logic rst_n;

    xcfr_byte_if rx_ch ();
    xcfr_item_if item_ch ();
    xcfr_cfg_if  cfg_ch ();

    int   error_count;
    int   pending_count;

    // markers as the block currently holds them
    logic [BYTE_W-1:0] cur_start = 8'd2;
    logic [BYTE_W-1:0] cur_end   = 8'd3;

    // idle control: percentages per request, gappy picks whether a frame has gaps
    int   gap_pct;
    int   stall_pct;
    bit   gappy;
    bit   hold_request;
    logic item_hold;
    int   frame_bytes;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    xor_checked_frame_receiver DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .items (item_ch),
        .cfg   (cfg_ch)
    );

    xcfr_frame_checker frame_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx_ch),
        .items         (item_ch),
        .cfg           (cfg_ch),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // ------------------------------------------------------------------------
    // item receiver: random stalls in stretches, quiet stretches in between,
    // and the long hold while the pressure test runs
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned stretch_left;
        bit          quiet;
        item_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stretch_left == 0)
            begin
                stretch_left = $urandom_range(8, 40);
                quiet        = ($urandom_range(0, 3) == 0);
            end
            stretch_left--;
            if (item_hold)
                item_ch.ready <= 1'b0;
            else if (!quiet && $urandom_range(1, 100) <= stall_pct)
                item_ch.ready <= 1'b0;
            else
                item_ch.ready <= 1'b1;
        end
    end

    // long hold-off, counted here so the sender keeps pushing bytes meanwhile
    initial
    begin
        item_hold <= 1'b0;
        wait (hold_request);
        @(posedge clk);
        item_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        item_hold <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // byte sender: optional gap, then hold the request until it is taken
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (gappy && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
    endtask

    // whole frame; the check byte is the xor of command and params unless corrupted
    task automatic send_frame(input int n, input param_fill_t fill,
                              input logic [BYTE_W-1:0] cmd,
                              input logic [BYTE_W-1:0] ack,
                              input bit corrupt_check,
                              input logic [BYTE_W-1:0] close_byte);
        logic [BYTE_W-1:0] p;
        logic [BYTE_W-1:0] check;
        gappy = ($urandom_range(0, 4) != 0);
        check = cmd;
        send_byte(cur_start);
        send_byte(BYTE_W'(n + FRAME_OVERHEAD));
        send_byte(cmd);
        for (int i = 0; i < n; i++)
        begin
            case (fill)
                FILL_ZERO: p = '0;
                FILL_ONES: p = '1;
                FILL_RAMP: p = BYTE_W'(i * 17);
                default:   p = BYTE_W'($urandom);
            endcase
            check = check ^ p;
            send_byte(p);
        end
        if (corrupt_check)
            check = check ^ BYTE_W'($urandom_range(1, 255));
        send_byte(check);
        send_byte(ack);
        send_byte(close_byte);
        frame_bytes += n + 6;
    endtask

    // start marker followed by a length outside 4..20
    task automatic send_bad_length(input logic [BYTE_W-1:0] len);
        send_byte(cur_start);
        send_byte(len);
        frame_bytes += 2;
    endtask

    // stop sending and wait until every predicted item has come out
    task automatic drain();
        rx_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending_count == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_START_MARKER)
            cur_start = value;
        else if (idx == REG_END_MARKER)
            cur_end = value;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int                pick;
        int                n;
        logic [BYTE_W-1:0] noise;
        logic [BYTE_W-1:0] closing;

        rst_n          <= 1'b0;
        rx_ch.valid    <= 1'b0;
        rx_ch.rx_byte  <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.index   <= '0;
        cfg_ch.data    <= '0;
        gap_pct   = 0;
        stall_pct = 0;
        gappy     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset markers, field extremes and every status
        send_frame(0, FILL_ZERO, 8'h00, 8'h00, 1'b0, cur_end);
        send_frame(MAX_PARAMS, FILL_ONES, 8'hFF, 8'hFF, 1'b0, cur_end);
        send_frame(1, FILL_RANDOM, 8'h3C, 8'hC3, 1'b1, cur_end);
        send_frame(0, FILL_ZERO, 8'h55, 8'hAA, 1'b1, cur_end);
        // wrong closing byte: frame dropped without an item
        send_frame(3, FILL_RAMP, 8'h12, 8'h34, 1'b0, cur_end ^ 8'h01);
        // closing byte equal to the start marker must not open a frame
        send_frame(2, FILL_RANDOM, 8'h5A, 8'hA5, 1'b0, cur_start);
        // lengths just outside the legal range and the extremes
        send_bad_length(8'd0);
        send_bad_length(8'd3);
        send_bad_length(8'd21);
        send_bad_length(8'd255);
        // stray bytes while hunting for a start marker
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(cur_end);
        drain();

        // write to an unused index leaves both markers alone
        write_reg(REG_UNUSED, 8'hAA);
        send_frame(2, FILL_RANDOM, 8'h66, 8'h99, 1'b0, cur_end);

        // pressure: stall the output for a long stretch while frames keep
        // coming, so the output register fills and the byte input backs up
        hold_request <= 1'b1;
        send_frame(MAX_PARAMS, FILL_RANDOM, 8'($urandom), 8'($urandom), 1'b0, cur_end);
        send_frame(0, FILL_RANDOM, 8'($urandom), 8'($urandom), 1'b0, cur_end);
        drain();

        // random rounds; later rounds set new markers, and each picks an idle pattern
        for (int r = 0; r < ROUNDS; r++)
        begin
            drain();
            case (r)
                1:
                begin
                    write_reg(REG_START_MARKER, 8'h00);
                    write_reg(REG_END_MARKER, 8'hFF);
                end
                2:
                begin
                    write_reg(REG_START_MARKER, 8'hFF);
                    write_reg(REG_END_MARKER, 8'h00);
                end
                3:
                begin
                    // same value opens and closes a frame
                    noise = 8'($urandom);
                    write_reg(REG_START_MARKER, noise);
                    write_reg(REG_END_MARKER, noise);
                end
                4:
                begin
                    write_reg(REG_END_MARKER, 8'($urandom));
                    write_reg(REG_START_MARKER, 8'($urandom));
                end
                default: ;
            endcase

            case (r % 4)
                1:       begin gap_pct = 60; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 60; end
                3:       begin gap_pct = 37; stall_pct = 37; end
                default: begin gap_pct = 0;  stall_pct = 0;  end
            endcase

            frame_bytes = 0;
            while (frame_bytes < ROUND_BYTES)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    // noise between frames, never a start marker
                    noise = 8'($urandom);
                    if (noise != cur_start)
                        send_byte(noise);
                end
                else if (pick < 16)
                begin
                    if ($urandom_range(0, 1) != 0)
                        send_bad_length(8'($urandom_range(0, 3)));
                    else
                        send_bad_length(8'($urandom_range(21, 255)));
                end
                else
                begin
                    n = ($urandom_range(0, 7) == 0) ? MAX_PARAMS : $urandom_range(0, 6);
                    closing = cur_end;
                    if ($urandom_range(0, 99) < 10)
                        closing = cur_end ^ 8'($urandom_range(1, 255));
                    send_frame(n, FILL_RANDOM, 8'($urandom), 8'($urandom),
                               $urandom_range(0, 99) < 15, closing);
                end
            end
        end

        // let the last items drain, then a quiet tail to catch strays
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && pending_count == 0)
            $display("xor_checked_frame_receiver: match");
        else
            $display("xor_checked_frame_receiver: mismatch");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("xor_checked_frame_receiver: mismatch");
        $finish;
    end

endmodule

@@ xor_checked_frame_receiver.f @@
sv/xcfr_pkg.sv
sv/xcfr_ifs.sv
sv/xcfr_datapath.sv
sv/xcfr_controller.sv
sv/xor_checked_frame_receiver.sv
test/xcfr_frame_checker.sv
test/tb_top.sv
